[rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 hash core package
// Round constants, initial hash values, SHA-256 bit functions and the
// command and status types shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int WORD_W  = 32;
	localparam int BLK_WORDS = 16;
	localparam int ROUNDS  = 64;

	localparam logic [2:0] SEL_IN   = 3'd0;
	localparam logic [2:0] SEL_MARK = 3'd1;
	localparam logic [2:0] SEL_ZERO = 3'd2;
	localparam logic [2:0] SEL_LHI  = 3'd3;
	localparam logic [2:0] SEL_LLO  = 3'd4;

	localparam logic [31:0] PAD_MARK_WORD = 32'h8000_0000;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic       push;
		logic [2:0] sel;
		logic       count;
		logic       load_work;
		logic       round;
		logic [5:0] rnd;
		logic       update;
		logic       finish;
	} sha_cmd_t;

	typedef struct packed {
		logic nib_full;
	} sha_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] v);
		big_sig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] v);
		big_sig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] v);
		small_sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] v);
		small_sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

endpackage

[rtl/sha_ctrl.sv]
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word intake, padding, the 64 compression rounds, the chaining
// update and the hand-off of the digest to the output register.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_ready,
	input  logic                last_word,
	output logic                digest_valid,
	input  logic                digest_ready,
	input  sha_pkg::sha_stat_t  stat,
	output sha_pkg::sha_cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [2:0] PH_NONE = 3'd0;
	localparam logic [2:0] PH_MARK = 3'd1;
	localparam logic [2:0] PH_ZERO = 3'd2;
	localparam logic [2:0] PH_LLO  = 3'd3;
	localparam logic [2:0] PH_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic [2:0] ph_q, ph_d;
	logic [3:0] fill_q, fill_d;
	logic [5:0] rnd_q, rnd_d;
	logic       oval_q, oval_d;
	logic       out_free;
	logic [2:0] after_upd;

	assign out_free     = !oval_q || digest_ready;
	assign msg_ready    = (state_q == ST_IDLE);
	assign digest_valid = oval_q;

	always_comb begin
		case (ph_q)
			PH_NONE: after_upd = ST_IDLE;
			PH_FIN:  after_upd = ST_DONE;
			default: after_upd = ST_PAD;
		endcase
	end

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		fill_d  = fill_q;
		rnd_d   = rnd_q;
		oval_d  = oval_q && !digest_ready;
		cmd     = '0;
		cmd.rnd = rnd_q;
		case (state_q)
			ST_IDLE: begin
				if (msg_valid) begin
					cmd.push  = 1'b1;
					cmd.sel   = sha_pkg::SEL_IN;
					cmd.count = 1'b1;
					fill_d    = fill_q + 4'd1;
					if (last_word) begin
						ph_d    = stat.nib_full ? PH_MARK : PH_ZERO;
						state_d = ST_PAD;
					end
					if (fill_q == 4'd15) begin
						cmd.load_work = 1'b1;
						rnd_d         = '0;
						state_d       = ST_COMP;
					end
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				fill_d   = fill_q + 4'd1;
				case (ph_q)
					PH_MARK: begin
						cmd.sel = sha_pkg::SEL_MARK;
						ph_d    = PH_ZERO;
					end
					PH_ZERO: begin
						if (fill_q == 4'd14) begin
							cmd.sel = sha_pkg::SEL_LHI;
							ph_d    = PH_LLO;
						end else begin
							cmd.sel = sha_pkg::SEL_ZERO;
						end
					end
					PH_LLO: begin
						cmd.sel = sha_pkg::SEL_LLO;
						ph_d    = PH_FIN;
					end
					default: begin
						cmd.push = 1'b0;
						fill_d   = fill_q;
					end
				endcase
				if (cmd.push && fill_q == 4'd15) begin
					cmd.load_work = 1'b1;
					rnd_d         = '0;
					state_d       = ST_COMP;
				end
			end
			ST_COMP: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = after_upd;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					oval_d     = 1'b1;
					ph_d       = PH_NONE;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PH_NONE;
			fill_q  <= '0;
			rnd_q   <= '0;
			oval_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			fill_q  <= fill_d;
			rnd_q   <= rnd_d;
			oval_q  <= oval_d;
		end
	end

endmodule

[rtl/sha_dp.sv]
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer and message schedule window, round variables, chaining
// hash, message bit counter and the digest output register.
// ----------------------------------------------------------------------------
module sha_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        message_word,
	input  logic [3:0]         valid_nibbles,
	input  logic               last_word,
	input  sha_pkg::sha_cmd_t  cmd,
	output sha_pkg::sha_stat_t stat,
	output logic [63:0]        digest_w0,
	output logic [63:0]        digest_w1,
	output logic [63:0]        digest_w2,
	output logic [63:0]        digest_w3
);

	logic [31:0] w_q     [16];
	logic [31:0] work_q  [8];
	logic [31:0] chain_q [8];
	logic [63:0] dig_q   [4];
	logic [63:0] bitcnt_q;

	logic [3:0]  nib_sat;
	logic [5:0]  nib_shift;
	logic [31:0] last_val;
	logic [31:0] in_val;
	logic [31:0] push_val;
	logic [31:0] sched_new;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch_v;
	logic [31:0] maj_v;

	assign nib_sat       = (valid_nibbles > 4'd8) ? 4'd8 : valid_nibbles;
	assign stat.nib_full = (nib_sat == 4'd8);
	assign nib_shift     = {nib_sat, 2'b00};
	assign last_val      = (message_word & ~(32'hffff_ffff >> nib_shift))
	                     | (sha_pkg::PAD_MARK_WORD >> nib_shift);
	assign in_val        = (last_word && !stat.nib_full) ? last_val : message_word;

	always_comb begin
		case (cmd.sel)
			sha_pkg::SEL_IN:   push_val = in_val;
			sha_pkg::SEL_MARK: push_val = sha_pkg::PAD_MARK_WORD;
			sha_pkg::SEL_LHI:  push_val = bitcnt_q[63:32];
			sha_pkg::SEL_LLO:  push_val = bitcnt_q[31:0];
			default:           push_val = '0;
		endcase
	end

	assign sched_new = sha_pkg::small_sig1(w_q[14]) + w_q[9]
	                 + sha_pkg::small_sig0(w_q[1]) + w_q[0];
	assign ch_v  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj_v = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
	             ^ (work_q[1] & work_q[2]);
	assign t1 = work_q[7] + sha_pkg::big_sig1(work_q[4]) + ch_v
	          + sha_pkg::ROUND_K[cmd.rnd] + w_q[0];
	assign t2 = sha_pkg::big_sig0(work_q[0]) + maj_v;

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= cmd.push ? push_val : sched_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			for (int i = 0; i < 4; i++) begin
				dig_q[i] <= {chain_q[2*i], chain_q[2*i+1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha_pkg::INIT_HASH[i];
				work_q[i]  <= '0;
			end
			bitcnt_q <= '0;
		end else begin
			if (cmd.count) begin
				bitcnt_q <= bitcnt_q + (last_word ? {58'd0, nib_shift} : 64'd32);
			end else if (cmd.finish) begin
				bitcnt_q <= '0;
			end
			if (cmd.load_work) begin
				for (int i = 0; i < 8; i++) begin
					work_q[i] <= chain_q[i];
				end
			end else if (cmd.round) begin
				work_q[7] <= work_q[6];
				work_q[6] <= work_q[5];
				work_q[5] <= work_q[4];
				work_q[4] <= work_q[3] + t1;
				work_q[3] <= work_q[2];
				work_q[2] <= work_q[1];
				work_q[1] <= work_q[0];
				work_q[0] <= t1 + t2;
			end
			if (cmd.update) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end else if (cmd.finish) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= sha_pkg::INIT_HASH[i];
				end
			end
		end
	end

	assign digest_w0 = dig_q[0];
	assign digest_w1 = dig_q[1];
	assign digest_w2 = dig_q[2];
	assign digest_w3 = dig_q[3];

endmodule

[rtl/sha256_hash_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 hash core
// Hashes a nibble-granular message given as 32-bit big-endian words.
// ----------------------------------------------------------------------------
// The message enters on the msg channel (msg_valid, msg_ready), one 32-bit
// word per item, first nibble in the top bits. The item flagged by
// last_word ends the message, and only its leading valid_nibbles nibbles
// count. The digest leaves on the digest channel as four 64-bit words.
// While idle, the core takes a word at each handshake. When a word fills
// a 16-word block, the block is compressed by one shared round unit doing
// one round per cycle, so msg_ready stays low through the rounds and the
// chaining update. After the last word the core pads one word per cycle,
// pausing while a block is compressed, and compresses one or two final
// blocks. The digest sits in an output register, so the next message may
// start while it waits; if a second digest is ready before the first is
// taken, the core holds it internally and stops taking words.
// Reset loads the initial hash values, clears the bit counter and leaves
// both channels empty.
// ----------------------------------------------------------------------------
module sha256_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [31:0] message_word,
	input  logic [3:0]  valid_nibbles,
	input  logic        last_word,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [63:0] digest_w0,
	output logic [63:0] digest_w1,
	output logic [63:0] digest_w2,
	output logic [63:0] digest_w3
);

	sha_pkg::sha_cmd_t  cmd;
	sha_pkg::sha_stat_t stat;

	sha_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.last_word    (last_word),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	sha_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.message_word  (message_word),
		.valid_nibbles (valid_nibbles),
		.last_word     (last_word),
		.cmd           (cmd),
		.stat          (stat),
		.digest_w0     (digest_w0),
		.digest_w1     (digest_w1),
		.digest_w2     (digest_w2),
		.digest_w3     (digest_w3)
	);

endmodule

[bench/sha256_hash_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 hash core testbench
// Streams messages of random length into the core and checks every digest
// against a SHA-256 model kept inside the bench. A short directed part covers
// the empty message, all-zero and all-one words, oversized nibble counts,
// dropped trailing nibbles and a final message that needs two padding
// blocks. Random traffic then runs with and without gaps on both channels.
// ----------------------------------------------------------------------------
module sha256_hash_core_tb;

	typedef struct packed {
		logic [63:0] w0;
		logic [63:0] w1;
		logic [63:0] w2;
		logic [63:0] w3;
	} digest_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 200;
	localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        msg_valid     = 1'b0;
	logic        msg_ready;
	logic [31:0] message_word  = '0;
	logic [3:0]  valid_nibbles = '0;
	logic        last_word     = 1'b0;
	logic        digest_valid;
	logic        digest_ready  = 1'b0;
	logic [63:0] digest_w0;
	logic [63:0] digest_w1;
	logic [63:0] digest_w2;
	logic [63:0] digest_w3;

	logic [31:0] chain_h [8];
	logic [31:0] block_words [16];
	int unsigned block_fill;
	logic [63:0] message_bits;
	digest_t     pending_digests [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned words_sent      = 0;
	int unsigned messages_sent   = 0;
	int unsigned digests_checked = 0;
	int unsigned mismatch_count  = 0;
	int unsigned idle_cycles     = 0;

	sha256_hash_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_valid     (msg_valid),
		.msg_ready     (msg_ready),
		.message_word  (message_word),
		.valid_nibbles (valid_nibbles),
		.last_word     (last_word),
		.digest_valid  (digest_valid),
		.digest_ready  (digest_ready),
		.digest_w0     (digest_w0),
		.digest_w1     (digest_w1),
		.digest_w2     (digest_w2),
		.digest_w3     (digest_w3)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic void load_initial_hash();
		for (int i = 0; i < 8; i++) chain_h[i] = SHA_H0[i];
		block_fill   = 0;
		message_bits = '0;
	endfunction

	function automatic void absorb_block();
		logic [31:0] sched [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int r = 0; r < 16; r++) sched[r] = block_words[r];
		for (int r = 16; r < 64; r++) begin
			s0 = ror32(sched[r-15], 7) ^ ror32(sched[r-15], 18) ^ (sched[r-15] >> 3);
			s1 = ror32(sched[r-2], 17) ^ ror32(sched[r-2], 19) ^ (sched[r-2] >> 10);
			sched[r] = sched[r-16] + s0 + sched[r-7] + s1;
		end
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
		e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
		for (int r = 0; r < 64; r++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[r] + sched[r];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endfunction

	function automatic void append_block_word(input logic [31:0] word);
		block_words[block_fill] = word;
		block_fill++;
		if (block_fill == 16) begin
			absorb_block();
			block_fill = 0;
		end
	endfunction

	// Advances the model by one accepted word and queues a digest on the last one.
	function automatic void predict_word(input logic [31:0] word, input logic [3:0] nib,
			input logic last);
		int unsigned n;
		digest_t     dg;
		if (!last) begin
			message_bits += 64'd32;
			append_block_word(word);
			return;
		end
		n = (nib > 4'd8) ? 8 : nib;
		message_bits += 64'(4 * n);
		if (n == 8) begin
			append_block_word(word);
			append_block_word(PAD_MARKER);
		end else begin
			append_block_word((word & ~(32'hffff_ffff >> (4 * n))) | (32'h8 << (4 * (7 - n))));
		end
		if (block_fill > 14)
			while (block_fill != 0) append_block_word('0);
		while (block_fill < 14) append_block_word('0);
		append_block_word(message_bits[63:32]);
		append_block_word(message_bits[31:0]);
		dg.w0 = {chain_h[0], chain_h[1]};
		dg.w1 = {chain_h[2], chain_h[3]};
		dg.w2 = {chain_h[4], chain_h[5]};
		dg.w3 = {chain_h[6], chain_h[7]};
		pending_digests.insert(pending_digests.size(), dg);
		load_initial_hash();
	endfunction

	function automatic logic [31:0] random_word();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) return '0;
		if (pick < 20) return '1;
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: digest %0d %s: got %h, expected %h",
			$time, digests_checked, what, got, want);
		mismatch_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input logic [31:0] word, input logic [3:0] nib,
			input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg_valid     <= 1'b1;
		message_word  <= word;
		valid_nibbles <= nib;
		last_word     <= last;
		@(posedge clk);
		while (!msg_ready) @(posedge clk);
		predict_word(word, nib, last);
		words_sent++;
		if (last) messages_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_message();
		int unsigned body_len;
		int unsigned pick;
		logic [3:0]  final_nib;
		pick = $urandom_range(0, 99);
		if (pick < 75) body_len = $urandom_range(0, 20);
		else if (pick < 95) body_len = $urandom_range(21, 40);
		else body_len = $urandom_range(41, 90);
		for (int i = 0; i < body_len; i++) send_word(random_word(), 4'($urandom), 1'b0);
		if ($urandom_range(0, 99) < 80) final_nib = 4'($urandom_range(0, 8));
		else final_nib = 4'($urandom_range(9, 15));
		send_word(random_word(), final_nib, 1'b1);
	endtask

	task automatic run_random_traffic(input int unsigned word_budget);
		int unsigned start;
		start = words_sent;
		while (words_sent - start < word_budget) send_random_message();
		msg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_directed_edges();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_word(32'h0000_0000, 4'd0, 1'b1);
		send_word(32'hffff_ffff, 4'd8, 1'b1);
		send_word(32'hffff_ffff, 4'd15, 1'b1);
		send_word(32'h1234_5678, 4'd9, 1'b1);
		send_word(32'hdead_beef, 4'd3, 1'b1);
		// Thirteen full words plus a full last word leave no room for the
		// length, so the padding spills into a second block.
		for (int i = 0; i < 13; i++)
			send_word((i % 2) ? 32'hffff_ffff : 32'h0000_0000, 4'(i + 3), 1'b0);
		send_word(32'ha5a5_a5a5, 4'd8, 1'b1);
		msg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_streaming();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random_traffic(360);
	endtask

	task automatic test_drain_pause();
		send_idle_pct  = 0;
		recv_stall_pct = 50;
		for (int i = 0; i < 3; i++) begin
			send_random_message();
			msg_valid <= 1'b0;
			while (pending_digests.size() != 0) @(negedge clk);
			@(negedge clk);
		end
	endtask

	task automatic test_sender_gaps();
		send_idle_pct  = 71;
		recv_stall_pct = 0;
		run_random_traffic(360);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct  = 0;
		recv_stall_pct = 71;
		run_random_traffic(360);
	endtask

	task automatic test_both_sides_idle();
		send_idle_pct  = 21;
		recv_stall_pct = 21;
		run_random_traffic(360);
	endtask

	always @(negedge clk) begin
		digest_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : digest_check
		digest_t want;
		if (arst_n && digest_valid && digest_ready) begin
			if (pending_digests.size() == 0) begin
				report_mismatch("arrived with none expected", digest_w0, 64'd0);
			end else begin
				want = pending_digests.pop_front();
				if (digest_w0 !== want.w0) report_mismatch("digest_w0", digest_w0, want.w0);
				if (digest_w1 !== want.w1) report_mismatch("digest_w1", digest_w1, want.w1);
				if (digest_w2 !== want.w2) report_mismatch("digest_w2", digest_w2, want.w2);
				if (digest_w3 !== want.w3) report_mismatch("digest_w3", digest_w3, want.w3);
			end
			digests_checked++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (msg_valid && msg_ready) || (digest_valid && digest_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		load_initial_hash();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_edges();
		test_streaming();
		test_drain_pause();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_sides_idle();
		while (pending_digests.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_digests.size() != 0)
			report_mismatch("never produced", 64'd0, 64'(pending_digests.size()));
		$display("Hashed %0d words in %0d messages and compared %0d digests,",
			words_sent, messages_sent, digests_checked);
		$display("with free flow, sender gaps, receiver stalls and a full drain.");
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[files.f]
rtl/sha_pkg.sv
rtl/sha_ctrl.sv
rtl/sha_dp.sv
rtl/sha256_hash_core.sv
bench/sha256_hash_core_tb.sv
